// ===== rtl/hpq_pkg.sv =====
// Shared types and constants of the max-heap priority queue.
`default_nettype none
package hpq_pkg;

    localparam int DATA_W  = 32;
    localparam int TOTAL_W = 7;
    localparam int UPC_W   = 4;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // Jump conditions of the control program.
    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_REQ,
        C_ERR,
        C_REMOVE,
        C_POS_ROOT,
        C_NOT_GT_PARENT,
        C_NO_BIGGER_CHILD,
        C_OUT_BUSY
    } t_cond;

    typedef enum logic [2:0] {
        RD_NONE,
        RD_PARENT,
        RD_LAST,
        RD_CHILDREN,
        RD_ROOT
    } t_rd_sel;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_CUR,
        WR_PARENT,
        WR_CHILD
    } t_wr_sel;

    typedef enum logic [2:0] {
        POS_KEEP,
        POS_NEW,
        POS_PARENT,
        POS_CHILD,
        POS_ROOT
    } t_pos_sel;

    typedef enum logic [1:0] {
        CNT_KEEP,
        CNT_INC,
        CNT_DEC
    } t_cnt_op;

    // One control word of the program.
    typedef struct packed {
        t_cond             cond;
        logic [UPC_W-1:0]  target;
        t_rd_sel           rd;
        t_wr_sel           wr;
        t_pos_sel          pos;
        t_cnt_op           cnt;
        logic              take_req;
        logic              load_cur;
        logic              load_out;
    } t_uword;

    // Status the datapath reports back to the sequencer.
    typedef struct packed {
        logic req_valid;
        logic err;
        logic remove;
        logic pos_root;
        logic cur_gt_parent;
        logic bigger_child;
        logic out_busy;
    } t_flags;

endpackage
`default_nettype wire

// ===== rtl/hpq_ifs.sv =====
// Request and response channel interfaces of the max-heap priority queue.
`default_nettype none
interface hpq_req_if;
    logic                               valid;
    logic                               ready;
    logic                               cmd;
    logic signed [hpq_pkg::DATA_W-1:0]  value;

    modport source (output valid, output cmd, output value, input ready);
    modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface hpq_rsp_if;
    logic                               valid;
    logic                               ready;
    logic signed [hpq_pkg::DATA_W-1:0]  top_value;
    logic [hpq_pkg::TOTAL_W-1:0]        entry_total;
    logic [1:0]                         status;

    modport source (output valid, output top_value, output entry_total, output status,
                    input ready);
    modport sink   (input valid, input top_value, input entry_total, input status,
                    output ready);
endinterface
`default_nettype wire

// ===== rtl/max_heap_priority_queue_top.sv =====
// Top level of the microcoded binary max-heap priority queue.
`default_nettype none
// A binary max-heap of signed 32-bit values in a one-based memory of CAPACITY
// words, so at most CAPACITY-1 entries are held. Each request either inserts a
// value (cmd 0) or removes the maximum (cmd 1). It produces exactly one
// response carrying three things: the maximum after the operation (zero when
// the heap is empty), the entry count (low seven bits), and a status. The
// status is ok, remove on an empty heap, or insert on a full heap, in which
// case the value is dropped.
// A small microcode program in a ROM steps a plain datapath. One request is
// worked on at a time. The response register lets the next request be taken
// while the previous response still waits. The program runs as follows:
//   - An insert bumps the count, then climbs the new value level by level
//     until it is not greater than its parent or reaches the root, and
//     writes it there.
//   - A remove reads the last entry, moves it to the root slot and sinks
//     it level by level below any bigger child, then writes it there.
//   - A rejected request skips the heap update and goes to the root read.
// Each level costs three program steps around the single heap memory: read,
// compare and move. An entry climbs or sinks at most log2(CAPACITY) - 1 levels.
// The load step holds for as long as the previous response is still waiting,
// so a stalled receiver holds up the queue. The next request can be taken in
// the cycle right after the load. The memory needs no clearing after reset,
// since only entries within the count are ever used.
module max_heap_priority_queue_top #(
    parameter int CAPACITY = 128
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    hpq_req_if.sink   i_req,
    hpq_rsp_if.source o_rsp
);

    hpq_pkg::t_uword w_ctrl;
    hpq_pkg::t_flags w_flags;

    // Step counter and program ROM; jumps are taken on datapath flags.
    hpq_useq u_useq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (w_flags),
        .o_ctrl  (w_ctrl)
    );

    // Heap memory, hole position, count and the response register.
    hpq_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_ctrl),
        .o_flags (w_flags),
        .i_req   (i_req),
        .o_rsp   (o_rsp)
    );

endmodule
`default_nettype wire

// ===== rtl/hpq_ram.sv =====
// Generic RAM with one write port and two registered read ports.
`default_nettype none
module hpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re_a,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_a,
    output      logic [WIDTH-1:0]         o_rdata_a,
    input  wire logic                     i_re_b,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output      logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re_a) begin
            o_rdata_a <= r_mem[i_raddr_a];
        end
        if (i_re_b) begin
            o_rdata_b <= r_mem[i_raddr_b];
        end
    end

endmodule
`default_nettype wire

// ===== rtl/hpq_useq.sv =====
// Microcode sequencer: step counter, program ROM and jump logic.
`default_nettype none
module hpq_useq (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire hpq_pkg::t_flags i_flags,
    output      hpq_pkg::t_uword o_ctrl
);

    localparam logic [hpq_pkg::UPC_W-1:0] S_IDLE     = 4'd0;
    localparam logic [hpq_pkg::UPC_W-1:0] S_CHK_ERR  = 4'd1;
    localparam logic [hpq_pkg::UPC_W-1:0] S_DISPATCH = 4'd2;
    localparam logic [hpq_pkg::UPC_W-1:0] S_INS      = 4'd3;
    localparam logic [hpq_pkg::UPC_W-1:0] S_UP_RD    = 4'd4;
    localparam logic [hpq_pkg::UPC_W-1:0] S_UP_CMP   = 4'd5;
    localparam logic [hpq_pkg::UPC_W-1:0] S_UP_MOVE  = 4'd6;
    localparam logic [hpq_pkg::UPC_W-1:0] S_UP_PLACE = 4'd7;
    localparam logic [hpq_pkg::UPC_W-1:0] S_REM_RD   = 4'd8;
    localparam logic [hpq_pkg::UPC_W-1:0] S_REM_LOAD = 4'd9;
    localparam logic [hpq_pkg::UPC_W-1:0] S_DN_RD    = 4'd10;
    localparam logic [hpq_pkg::UPC_W-1:0] S_DN_CMP   = 4'd11;
    localparam logic [hpq_pkg::UPC_W-1:0] S_DN_MOVE  = 4'd12;
    localparam logic [hpq_pkg::UPC_W-1:0] S_DN_PLACE = 4'd13;
    localparam logic [hpq_pkg::UPC_W-1:0] S_FIN      = 4'd14;
    localparam logic [hpq_pkg::UPC_W-1:0] S_DONE     = 4'd15;

    // The program. A word that names no jump falls through to the next step.
    function automatic hpq_pkg::t_uword f_rom(input logic [hpq_pkg::UPC_W-1:0] step);
        hpq_pkg::t_uword w;
        w = '0;
        unique case (step)
            S_IDLE: begin
                w.take_req = 1'b1;
                w.cond     = hpq_pkg::C_NO_REQ;
                w.target   = S_IDLE;
            end
            S_CHK_ERR: begin
                w.cond   = hpq_pkg::C_ERR;
                w.target = S_FIN;
            end
            S_DISPATCH: begin
                w.cond   = hpq_pkg::C_REMOVE;
                w.target = S_REM_RD;
            end
            S_INS: begin
                w.cnt = hpq_pkg::CNT_INC;
                w.pos = hpq_pkg::POS_NEW;
            end
            S_UP_RD: begin
                w.rd     = hpq_pkg::RD_PARENT;
                w.cond   = hpq_pkg::C_POS_ROOT;
                w.target = S_UP_PLACE;
            end
            S_UP_CMP: begin
                w.cond   = hpq_pkg::C_NOT_GT_PARENT;
                w.target = S_UP_PLACE;
            end
            S_UP_MOVE: begin
                w.wr     = hpq_pkg::WR_PARENT;
                w.pos    = hpq_pkg::POS_PARENT;
                w.cond   = hpq_pkg::C_ALWAYS;
                w.target = S_UP_RD;
            end
            S_UP_PLACE: begin
                w.wr     = hpq_pkg::WR_CUR;
                w.cond   = hpq_pkg::C_ALWAYS;
                w.target = S_FIN;
            end
            S_REM_RD: begin
                w.rd = hpq_pkg::RD_LAST;
            end
            S_REM_LOAD: begin
                w.load_cur = 1'b1;
                w.cnt      = hpq_pkg::CNT_DEC;
                w.pos      = hpq_pkg::POS_ROOT;
            end
            S_DN_RD: begin
                w.rd = hpq_pkg::RD_CHILDREN;
            end
            S_DN_CMP: begin
                w.cond   = hpq_pkg::C_NO_BIGGER_CHILD;
                w.target = S_DN_PLACE;
            end
            S_DN_MOVE: begin
                w.wr     = hpq_pkg::WR_CHILD;
                w.pos    = hpq_pkg::POS_CHILD;
                w.cond   = hpq_pkg::C_ALWAYS;
                w.target = S_DN_RD;
            end
            S_DN_PLACE: begin
                w.wr = hpq_pkg::WR_CUR;
            end
            S_FIN: begin
                w.rd = hpq_pkg::RD_ROOT;
            end
            S_DONE: begin
                w.load_out = 1'b1;
                w.cond     = hpq_pkg::C_OUT_BUSY;
                w.target   = S_DONE;
            end
            default: begin
                w.cond   = hpq_pkg::C_ALWAYS;
                w.target = S_IDLE;
            end
        endcase
        return w;
    endfunction

    logic [hpq_pkg::UPC_W-1:0] r_upc;
    logic [hpq_pkg::UPC_W-1:0] n_upc;
    logic                      w_jump;
    hpq_pkg::t_uword           w_word;

    assign w_word = f_rom(r_upc);
    assign o_ctrl = w_word;

    always_comb begin
        unique case (w_word.cond)
            hpq_pkg::C_NEVER:           w_jump = 1'b0;
            hpq_pkg::C_ALWAYS:          w_jump = 1'b1;
            hpq_pkg::C_NO_REQ:          w_jump = !i_flags.req_valid;
            hpq_pkg::C_ERR:             w_jump = i_flags.err;
            hpq_pkg::C_REMOVE:          w_jump = i_flags.remove;
            hpq_pkg::C_POS_ROOT:        w_jump = i_flags.pos_root;
            hpq_pkg::C_NOT_GT_PARENT:   w_jump = !i_flags.cur_gt_parent;
            hpq_pkg::C_NO_BIGGER_CHILD: w_jump = !i_flags.bigger_child;
            hpq_pkg::C_OUT_BUSY:        w_jump = i_flags.out_busy;
            default:                    w_jump = 1'b0;
        endcase
        n_upc = w_jump ? w_word.target : r_upc + 4'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= S_IDLE;
        end else begin
            r_upc <= n_upc;
        end
    end

    // A finished item always hands its result over before the next one is taken.
    a_done_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_upc == S_DONE && !i_flags.out_busy) |=> (r_upc == S_IDLE))
        else $error("sequencer did not return to idle after result load");

    // The sift-down compare only ever follows a child read.
    a_cmp_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_upc == S_DN_CMP) |-> ($past(r_upc) == S_DN_RD))
        else $error("child compare without a preceding child read");

    // An error item skips every heap update and goes straight to the root read.
    a_err_skips: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_upc == S_CHK_ERR && i_flags.err) |=> (r_upc == S_FIN))
        else $error("error item did not skip the heap update");

endmodule
`default_nettype wire

// ===== rtl/hpq_dpath.sv =====
// Heap datapath: heap memory, position and count registers, compare and output register.
`default_nettype none
module hpq_dpath #(
    parameter int CAPACITY = 128
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire hpq_pkg::t_uword i_ctrl,
    output      hpq_pkg::t_flags o_flags,
    hpq_req_if.sink              i_req,
    hpq_rsp_if.source            o_rsp
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = (AW > hpq_pkg::TOTAL_W) ? AW : hpq_pkg::TOTAL_W;

    logic                        r_cmd;
    logic [1:0]                  r_status;
    logic [hpq_pkg::DATA_W-1:0]  r_cur;
    logic [AW-1:0]               r_pos;
    logic [AW-1:0]               r_count;

    logic                        r_ovalid;
    logic [hpq_pkg::DATA_W-1:0]  r_otop;
    logic [hpq_pkg::TOTAL_W-1:0] r_ototal;
    logic [1:0]                  r_ostatus;

    logic                        w_accept;
    logic                        w_full;
    logic                        w_out_busy;
    logic [AW:0]                 w_left;
    logic [AW:0]                 w_right;
    logic [AW:0]                 w_count_ext;
    logic                        w_left_ok;
    logic                        w_right_ok;
    logic                        w_pick_right;
    logic [hpq_pkg::DATA_W-1:0]  w_child_val;
    logic [AW:0]                 w_child_idx;
    logic [CW-1:0]               w_total_ext;

    logic                        w_we;
    logic [hpq_pkg::DATA_W-1:0]  w_wdata;
    logic                        w_re_a;
    logic                        w_re_b;
    logic [AW-1:0]               w_raddr_a;
    logic [hpq_pkg::DATA_W-1:0]  w_rd_a;
    logic [hpq_pkg::DATA_W-1:0]  w_rd_b;

    hpq_ram #(
        .WIDTH (hpq_pkg::DATA_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (r_pos),
        .i_wdata   (w_wdata),
        .i_re_a    (w_re_a),
        .i_raddr_a (w_raddr_a),
        .o_rdata_a (w_rd_a),
        .i_re_b    (w_re_b),
        .i_raddr_b (w_right[AW-1:0]),
        .o_rdata_b (w_rd_b)
    );

    assign i_req.ready = i_ctrl.take_req;
    assign w_accept    = i_req.valid && i_ctrl.take_req;
    assign w_full      = (r_count == AW'(CAPACITY - 1));
    assign w_out_busy  = r_ovalid && !o_rsp.ready;

    // Children of the hole; only those within the count take part.
    assign w_left       = {r_pos, 1'b0};
    assign w_right      = {r_pos, 1'b1};
    assign w_count_ext  = {1'b0, r_count};
    assign w_left_ok    = (w_left <= w_count_ext);
    assign w_right_ok   = (w_right <= w_count_ext);
    assign w_pick_right = w_right_ok && ($signed(w_rd_b) > $signed(w_rd_a));
    assign w_child_val  = w_pick_right ? w_rd_b : w_rd_a;
    assign w_child_idx  = w_pick_right ? w_right : w_left;
    assign w_total_ext  = CW'(r_count);

    always_comb begin
        w_re_a    = 1'b1;
        w_re_b    = 1'b0;
        w_raddr_a = r_pos;
        case (i_ctrl.rd)
            hpq_pkg::RD_PARENT:   w_raddr_a = r_pos >> 1;
            hpq_pkg::RD_LAST:     w_raddr_a = r_count;
            hpq_pkg::RD_CHILDREN: begin
                w_raddr_a = w_left[AW-1:0];
                w_re_b    = 1'b1;
            end
            hpq_pkg::RD_ROOT:     w_raddr_a = AW'(1);
            default:              w_re_a    = 1'b0;
        endcase

        w_we    = 1'b1;
        w_wdata = r_cur;
        case (i_ctrl.wr)
            hpq_pkg::WR_CUR:    w_wdata = r_cur;
            hpq_pkg::WR_PARENT: w_wdata = w_rd_a;
            hpq_pkg::WR_CHILD:  w_wdata = w_child_val;
            default:            w_we    = 1'b0;
        endcase
    end

    always_comb begin
        o_flags.req_valid     = i_req.valid;
        o_flags.err           = (r_status != hpq_pkg::ST_OK);
        o_flags.remove        = (r_cmd == hpq_pkg::CMD_REMOVE);
        o_flags.pos_root      = (r_pos == AW'(1));
        o_flags.cur_gt_parent = ($signed(r_cur) > $signed(w_rd_a));
        o_flags.bigger_child  = w_left_ok && ($signed(w_child_val) > $signed(r_cur));
        o_flags.out_busy      = w_out_busy;
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= i_req.cmd;
            r_cur <= i_req.value;
            if (i_req.cmd == hpq_pkg::CMD_INSERT) begin
                r_status <= w_full ? hpq_pkg::ST_FULL : hpq_pkg::ST_OK;
            end else begin
                r_status <= (r_count == '0) ? hpq_pkg::ST_EMPTY : hpq_pkg::ST_OK;
            end
        end else if (i_ctrl.load_cur) begin
            r_cur <= w_rd_a;
        end

        case (i_ctrl.pos)
            hpq_pkg::POS_NEW:    r_pos <= r_count + AW'(1);
            hpq_pkg::POS_PARENT: r_pos <= r_pos >> 1;
            hpq_pkg::POS_CHILD:  r_pos <= w_child_idx[AW-1:0];
            hpq_pkg::POS_ROOT:   r_pos <= AW'(1);
            default:             r_pos <= r_pos;
        endcase

        if (i_ctrl.load_out && !w_out_busy) begin
            r_otop    <= (r_count != '0) ? w_rd_a : '0;
            r_ototal  <= w_total_ext[hpq_pkg::TOTAL_W-1:0];
            r_ostatus <= r_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            case (i_ctrl.cnt)
                hpq_pkg::CNT_INC: r_count <= r_count + AW'(1);
                hpq_pkg::CNT_DEC: r_count <= r_count - AW'(1);
                default:          r_count <= r_count;
            endcase
            if (i_ctrl.load_out && !w_out_busy) begin
                r_ovalid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_rsp.valid       = r_ovalid;
    assign o_rsp.top_value   = r_otop;
    assign o_rsp.entry_total = r_ototal;
    assign o_rsp.status      = r_ostatus;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= AW'(CAPACITY - 1))
        else $error("entry count beyond capacity");

    a_no_write_slot0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (r_pos != '0))
        else $error("heap write to unused slot zero");

    a_empty_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(r_ovalid) && r_ostatus == hpq_pkg::ST_EMPTY) |->
            (r_ototal == '0 && r_otop == '0))
        else $error("empty-heap result reports entries");

endmodule
`default_nettype wire
